// ===== src/bhsl_pkg.sv =====
`timescale 1ns / 1ps
// shared types, register indexes and reset values for the button hold and status led controller
// no dependencies

package bhsl_pkg;

	localparam int unsigned HOLD_W  = 17;
	localparam int unsigned BLINK_W = 10;
	localparam int unsigned LINK_W  = 16;
	localparam int unsigned OPEN_W  = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 17;

	localparam logic [OPEN_W-1:0]  WINDOW_OPEN_RST  = 16'd5000;
	localparam logic [OPEN_W-1:0]  WINDOW_CLOSE_RST = 16'd10000;
	localparam logic [HOLD_W-1:0]  RESET_HOLD_RST   = 17'd25000;
	localparam logic [BLINK_W-1:0] BLINK_HALF_RST   = 10'd150;
	localparam logic [LINK_W-1:0]  LINK_ON_RST      = 16'd350;
	localparam logic [LINK_W-1:0]  LINK_REST_RST    = 16'd1000;

	localparam logic [HOLD_W-1:0]  HOLD_MAX  = '1;
	localparam logic [BLINK_W-1:0] BLINK_MAX = '1;
	localparam logic [LINK_W-1:0]  LINK_MAX  = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_OPEN  = 3'd0,
		CFG_WINDOW_CLOSE = 3'd1,
		CFG_RESET_HOLD   = 3'd2,
		CFG_BLINK_HALF   = 3'd3,
		CFG_LINK_ON      = 3'd4,
		CFG_LINK_REST    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [OPEN_W-1:0]  window_open_ms;
		logic [OPEN_W-1:0]  window_close_ms;
		logic [HOLD_W-1:0]  reset_hold_ms;
		logic [BLINK_W-1:0] blink_half_period_ms;
		logic [LINK_W-1:0]  link_on_ms;
		logic [LINK_W-1:0]  link_rest_ms;
	} cfg_t;

	typedef struct packed {
		logic               held;
		logic [HOLD_W-1:0]  hold_ms;
		logic               window_seen;
		logic               window_open;
		logic               blink_running;
		logic [BLINK_W-1:0] blink_ms;
		logic               blink_phase;
		logic               reset_done;
		logic               owner_button;
		logic               led_level;
		logic               link_pulse_on;
		logic [LINK_W-1:0]  link_on_count;
		logic               link_resting;
		logic [LINK_W-1:0]  link_rest_count;
	} state_t;

	typedef struct packed {
		logic led_on;
		logic start_programming;
		logic factory_reset;
		logic window_active;
		logic led_owned;
	} result_t;

endpackage

// ===== src/bhsl_cfg_regs.sv =====
`timescale 1ns / 1ps
// configuration register file for the button hold and status led controller
// depends on bhsl_pkg

module bhsl_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [bhsl_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [bhsl_pkg::CFG_DATA_W-1:0]    wr_data,
	output bhsl_pkg::cfg_t                     cfg
);

	bhsl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_open_ms       <= bhsl_pkg::WINDOW_OPEN_RST;
			cfg_q.window_close_ms      <= bhsl_pkg::WINDOW_CLOSE_RST;
			cfg_q.reset_hold_ms        <= bhsl_pkg::RESET_HOLD_RST;
			cfg_q.blink_half_period_ms <= bhsl_pkg::BLINK_HALF_RST;
			cfg_q.link_on_ms           <= bhsl_pkg::LINK_ON_RST;
			cfg_q.link_rest_ms         <= bhsl_pkg::LINK_REST_RST;
		end else if (wr_en) begin
			case (bhsl_pkg::cfg_idx_t'(wr_index))
				bhsl_pkg::CFG_WINDOW_OPEN: begin
					cfg_q.window_open_ms <= wr_data[bhsl_pkg::OPEN_W-1:0];
				end
				bhsl_pkg::CFG_WINDOW_CLOSE: begin
					cfg_q.window_close_ms <= wr_data[bhsl_pkg::OPEN_W-1:0];
				end
				bhsl_pkg::CFG_RESET_HOLD: begin
					cfg_q.reset_hold_ms <= wr_data[bhsl_pkg::HOLD_W-1:0];
				end
				bhsl_pkg::CFG_BLINK_HALF: begin
					cfg_q.blink_half_period_ms <= wr_data[bhsl_pkg::BLINK_W-1:0];
				end
				bhsl_pkg::CFG_LINK_ON: begin
					cfg_q.link_on_ms <= wr_data[bhsl_pkg::LINK_W-1:0];
				end
				bhsl_pkg::CFG_LINK_REST: begin
					cfg_q.link_rest_ms <= wr_data[bhsl_pkg::LINK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/bhsl_tick.sv =====
`timescale 1ns / 1ps
// per-tick state update: link pulse timing, button hold timing, led ownership and blinking
// depends on bhsl_pkg

module bhsl_tick (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               button_down,
	input  logic               link_check,
	input  logic               link_ok,
	input  bhsl_pkg::cfg_t     cfg,
	output bhsl_pkg::result_t  result
);

	bhsl_pkg::state_t st_q;
	bhsl_pkg::state_t st_d;

	function automatic bhsl_pkg::state_t link_event(
		input bhsl_pkg::state_t s,
		input logic idle,
		input bhsl_pkg::cfg_t c
	);
		bhsl_pkg::state_t r;
		r = s;
		if (!r.owner_button && !(r.link_resting && r.link_rest_count < c.link_rest_ms)) begin
			if (r.link_resting && r.link_rest_count > c.link_rest_ms) begin
				r.link_resting = 1'b0;
			end
			if (!r.link_pulse_on && !idle) begin
				r.link_pulse_on = 1'b1;
				r.link_on_count = '0;
				r.led_level     = 1'b1;
			end else if (r.link_pulse_on && idle) begin
				if (r.link_on_count > c.link_on_ms) begin
					r.link_resting    = 1'b1;
					r.link_pulse_on   = 1'b0;
					r.led_level       = 1'b0;
					r.link_rest_count = '0;
				end
			end
		end
		return r;
	endfunction

	always_comb begin
		bhsl_pkg::state_t n;
		logic start_p;
		logic reset_p;
		logic past_open;
		n         = st_q;
		start_p   = 1'b0;
		reset_p   = 1'b0;
		past_open = 1'b0;

		// saturating counters
		if (n.link_pulse_on && n.link_on_count != bhsl_pkg::LINK_MAX) begin
			n.link_on_count = n.link_on_count + 1'b1;
		end
		if (n.link_resting && n.link_rest_count != bhsl_pkg::LINK_MAX) begin
			n.link_rest_count = n.link_rest_count + 1'b1;
		end
		if (n.blink_running && n.blink_ms != bhsl_pkg::BLINK_MAX) begin
			n.blink_ms = n.blink_ms + 1'b1;
		end

		if (link_check) begin
			n = link_event(n, 1'b1, cfg);
		end
		if (link_ok) begin
			n = link_event(n, 1'b0, cfg);
		end

		if (!button_down) begin
			start_p = n.window_open && n.held;
			if (n.held) begin
				n.held          = 1'b0;
				n.window_seen   = 1'b0;
				n.reset_done    = 1'b0;
				n.blink_running = 1'b0;
				n.window_open   = 1'b0;
				n.owner_button  = 1'b0;
				n.led_level     = 1'b0;
				n.hold_ms       = '0;
				n.blink_ms      = '0;
			end
		end else begin
			if (!n.held) begin
				n.held          = 1'b1;
				n.window_seen   = 1'b0;
				n.reset_done    = 1'b0;
				n.blink_running = 1'b0;
				n.window_open   = 1'b0;
				n.hold_ms       = '0;
			end else if (n.hold_ms != bhsl_pkg::HOLD_MAX) begin
				n.hold_ms = n.hold_ms + 1'b1;
			end
			past_open = n.hold_ms >= {1'b0, cfg.window_open_ms};
			if (past_open && !n.window_seen) begin
				n.window_seen  = 1'b1;
				n.window_open  = 1'b1;
				n.owner_button = 1'b1;
			end
			if (n.hold_ms >= {1'b0, cfg.window_close_ms} && n.window_open) begin
				n.window_open = 1'b0;
			end
			if (past_open && !n.blink_running) begin
				n.blink_running = 1'b1;
				n.blink_ms      = '0;
			end
			if (n.blink_running && !n.reset_done && n.blink_ms >= cfg.blink_half_period_ms) begin
				n.blink_phase = !n.blink_phase;
				n.led_level   = n.blink_phase;
				n.blink_ms    = '0;
			end
			if (n.hold_ms >= cfg.reset_hold_ms && !n.reset_done && !n.window_open) begin
				n.reset_done = 1'b1;
				n.led_level  = 1'b0;
				reset_p      = 1'b1;
			end
		end

		st_d                     = n;
		result.led_on            = n.led_level;
		result.start_programming = start_p;
		result.factory_reset     = reset_p;
		result.window_active     = n.window_open;
		result.led_owned         = n.owner_button;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= st_d;
		end
	end

endmodule

// ===== src/button_hold_and_status_led_controller.sv =====
`timescale 1ns / 1ps
// top level of the button hold and status led controller: input register, tick logic, result register
// depends on bhsl_pkg, bhsl_cfg_regs, bhsl_tick
//
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | button_down, link_check, link_ok
// out     | output    | out_valid / out_stall | led_on, start_programming, factory_reset,
//         |           |                       | window_active, led_owned
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per clock sustained while out_stall is low; an item is held in the input register,
// then the tick logic updates its state and the result register captures the result.
// the state update is combinational counters and compares in bhsl_tick.
// reset clears the valid flags and tick state and loads default thresholds; cfg_ready is always high.
// while out_stall holds a result, one more item waits in the input register, then in_stall rises.

module button_hold_and_status_led_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             button_down,
	input  logic                             link_check,
	input  logic                             link_ok,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             led_on,
	output logic                             start_programming,
	output logic                             factory_reset,
	output logic                             window_active,
	output logic                             led_owned,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bhsl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bhsl_pkg::CFG_DATA_W-1:0]  cfg_data
);

	bhsl_pkg::cfg_t    cfg;
	bhsl_pkg::result_t res;
	bhsl_pkg::result_t res_s2;

	logic valid_s1;
	logic button_s1;
	logic check_s1;
	logic ok_s1;
	logic valid_s2;
	logic adv;
	logic step;
	logic in_take;

	assign cfg_ready = 1'b1;
	assign adv       = !valid_s2 || !out_stall;
	assign step      = valid_s1 && adv;
	assign in_stall  = valid_s1 && !adv;
	assign in_take   = in_valid && !in_stall;

	bhsl_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bhsl_tick u_tick (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.button_down (button_s1),
		.link_check  (check_s1),
		.link_ok     (ok_s1),
		.cfg         (cfg),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			button_s1 <= button_down;
			check_s1  <= link_check;
			ok_s1     <= link_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid         = valid_s2;
	assign led_on            = res_s2.led_on;
	assign start_programming = res_s2.start_programming;
	assign factory_reset     = res_s2.factory_reset;
	assign window_active     = res_s2.window_active;
	assign led_owned         = res_s2.led_owned;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for button_hold_and_status_led_controller: directed rows, holds
// through every threshold, extreme link times, then random press sequences under several settings
// depends on bhsl_pkg and the block's top level

module tb;

	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned PRINT_CAP   = 100;
	localparam int unsigned N_RAND      = 4;
	localparam int unsigned RAND_ITEMS  = 340;
	localparam logic [bhsl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	typedef struct packed {
		logic              btn;
		logic              chk;
		logic              ok;
		logic              fixed;
		bhsl_pkg::result_t res;
	} tick_t;

	// rows: button, check, ok, fixed result flag, {led, start, reset, window, owned}
	localparam logic [0:9][8:0] ROWS_DEFAULT = {
		{3'b000, 1'b1, 5'b00000},
		{3'b010, 1'b1, 5'b00000},
		{3'b001, 1'b1, 5'b10000},
		{3'b011, 1'b1, 5'b10000},
		{3'b100, 1'b1, 5'b10000},
		{3'b111, 1'b0, 5'b00000},
		{3'b000, 1'b1, 5'b00000},
		{3'b001, 1'b0, 5'b00000},
		{3'b110, 1'b0, 5'b00000},
		{3'b000, 1'b0, 5'b00000}
	};

	// all thresholds zero: window, blink and reset all fire on the press tick
	localparam logic [0:7][8:0] ROWS_ZERO = {
		{3'b100, 1'b1, 5'b00101},
		{3'b111, 1'b1, 5'b00001},
		{3'b011, 1'b1, 5'b00000},
		{3'b001, 1'b0, 5'b00000},
		{3'b010, 1'b0, 5'b00000},
		{3'b110, 1'b0, 5'b00000},
		{3'b100, 1'b0, 5'b00000},
		{3'b000, 1'b0, 5'b00000}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic button_down = 1'b0;
	logic link_check = 1'b0;
	logic link_ok = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic led_on;
	logic start_programming;
	logic factory_reset;
	logic window_active;
	logic led_owned;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bhsl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bhsl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	button_hold_and_status_led_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.button_down(button_down),
		.link_check(link_check),
		.link_ok(link_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.led_on(led_on),
		.start_programming(start_programming),
		.factory_reset(factory_reset),
		.window_active(window_active),
		.led_owned(led_owned),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor thresholds
	logic [15:0] th_open, th_close, th_lon, th_lrest;
	logic [16:0] th_reset;
	logic [9:0]  th_blink;

	// predictor state
	logic        btn_held, win_seen, win_open, blink_on, blink_ph, rst_fired, btn_owns, led;
	logic        lp_on, lp_rest;
	logic [16:0] hold_cnt;
	logic [9:0]  blink_cnt;
	logic [15:0] lp_cnt, lr_cnt;

	tick_t             tick_q [$];
	bhsl_pkg::result_t status_due [$];
	tick_t             cur;
	bhsl_pkg::result_t pred;
	bhsl_pkg::result_t got;
	bhsl_pkg::result_t want;
	int unsigned errors = 0;
	int unsigned printed = 0;
	int unsigned n_items = 0;
	int unsigned cycles = 0;
	int send_gap = 0;
	int hold_left = 0;
	bit idle_on = 1'b0;
	bit long_hold_req = 1'b0;
	string fld_name [5] = '{"led_on", "start_programming", "factory_reset", "window_active",
		"led_owned"};

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("button_hold_and_status_led_controller: mismatch");
			$finish;
		end
	end

	function automatic void status_reset();
		th_open  = bhsl_pkg::WINDOW_OPEN_RST;
		th_close = bhsl_pkg::WINDOW_CLOSE_RST;
		th_reset = bhsl_pkg::RESET_HOLD_RST;
		th_blink = bhsl_pkg::BLINK_HALF_RST;
		th_lon   = bhsl_pkg::LINK_ON_RST;
		th_lrest = bhsl_pkg::LINK_REST_RST;
		{btn_held, win_seen, win_open, blink_on, blink_ph, rst_fired, btn_owns, led} = '0;
		{lp_on, lp_rest} = '0;
		hold_cnt = '0;
		blink_cnt = '0;
		lp_cnt = '0;
		lr_cnt = '0;
	endfunction

	function automatic void threshold_set(input logic [bhsl_pkg::CFG_IDX_W-1:0] idx,
		input logic [bhsl_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			bhsl_pkg::CFG_WINDOW_OPEN:  th_open  = data[15:0];
			bhsl_pkg::CFG_WINDOW_CLOSE: th_close = data[15:0];
			bhsl_pkg::CFG_RESET_HOLD:   th_reset = data[16:0];
			bhsl_pkg::CFG_BLINK_HALF:   th_blink = data[9:0];
			bhsl_pkg::CFG_LINK_ON:      th_lon   = data[15:0];
			bhsl_pkg::CFG_LINK_REST:    th_lrest = data[15:0];
			default: ;
		endcase
	endfunction

	function automatic void link_event(input logic is_check);
		if (btn_owns)
			return;
		if (lp_rest && lr_cnt < th_lrest)
			return;
		if (lp_rest && lr_cnt > th_lrest)
			lp_rest = 1'b0;
		if (!lp_on && !is_check) begin
			lp_on = 1'b1;
			lp_cnt = '0;
			led = 1'b1;
		end else if (lp_on && is_check) begin
			if (lp_cnt > th_lon) begin
				lp_rest = 1'b1;
				lp_on = 1'b0;
				led = 1'b0;
				lr_cnt = '0;
			end
		end
	endfunction

	function automatic bhsl_pkg::result_t tick_status(input logic b, input logic c,
		input logic o);
		bhsl_pkg::result_t r;
		r = '0;
		if (lp_on && lp_cnt != bhsl_pkg::LINK_MAX)
			lp_cnt = lp_cnt + 1'b1;
		if (lp_rest && lr_cnt != bhsl_pkg::LINK_MAX)
			lr_cnt = lr_cnt + 1'b1;
		if (blink_on && blink_cnt != bhsl_pkg::BLINK_MAX)
			blink_cnt = blink_cnt + 1'b1;
		if (c)
			link_event(1'b1);
		if (o)
			link_event(1'b0);
		if (!b) begin
			if (win_open && btn_held)
				r.start_programming = 1'b1;
			if (btn_held) begin
				{btn_held, win_seen, rst_fired, blink_on, win_open, btn_owns, led} = '0;
				hold_cnt = '0;
				blink_cnt = '0;
			end
		end else begin
			if (!btn_held) begin
				btn_held = 1'b1;
				{win_seen, rst_fired, blink_on, win_open} = '0;
				hold_cnt = '0;
			end else if (hold_cnt != bhsl_pkg::HOLD_MAX) begin
				hold_cnt = hold_cnt + 1'b1;
			end
			if (hold_cnt >= th_open && !win_seen) begin
				win_seen = 1'b1;
				win_open = 1'b1;
				btn_owns = 1'b1;
			end
			if (hold_cnt >= th_close && win_open)
				win_open = 1'b0;
			if (hold_cnt >= th_open && !blink_on) begin
				blink_on = 1'b1;
				blink_cnt = '0;
			end
			if (blink_on && !rst_fired && blink_cnt >= th_blink) begin
				blink_ph = ~blink_ph;
				led = blink_ph;
				blink_cnt = '0;
			end
			if (hold_cnt >= th_reset && !rst_fired && !win_open) begin
				rst_fired = 1'b1;
				led = 1'b0;
				r.factory_reset = 1'b1;
			end
		end
		r.led_on = led;
		r.window_active = win_open;
		r.led_owned = btn_owns;
		return r;
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pred = tick_status(cur.btn, cur.chk, cur.ok);
				status_due.push_back(cur.fixed ? cur.res : pred);
				n_items++;
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (idle_on && tick_q.size() > 0 && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(1, 6) - 1;
					in_valid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					cur = tick_q.pop_front();
					in_valid <= 1'b1;
					button_down <= cur.btn;
					link_check <= cur.chk;
					link_ok <= cur.ok;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {led_on, start_programming, factory_reset, window_active, led_owned};
				if (status_due.size() == 0) begin
					errors++;
					if (printed < PRINT_CAP) begin
						printed++;
						$display("%0t: item out with none pending, expected nothing, got %b",
							$time, got);
					end
				end else begin
					want = status_due.pop_front();
					for (int i = 0; i < 5; i++) begin
						if (want[4-i] !== got[4-i]) begin
							errors++;
							if (printed < PRINT_CAP) begin
								printed++;
								$display("%0t: %s expected %b got %b", $time, fld_name[i],
									want[4-i], got[4-i]);
							end
						end
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 79;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(1, 6) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic one_in(input int unsigned n);
		return $urandom_range(0, n - 1) == 0;
	endfunction

	task automatic add_tick(input logic b, input logic c, input logic o);
		tick_t t;
		t = '0;
		t.btn = b;
		t.chk = c;
		t.ok = o;
		tick_q.push_back(t);
	endtask

	task automatic quiesce();
		@(negedge clk);
		while (tick_q.size() != 0 || in_valid || status_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [bhsl_pkg::CFG_IDX_W-1:0] idx,
		input logic [bhsl_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		threshold_set(idx, data);
	endtask

	// unused upper data bits carry random junk
	task automatic load_cfg(input logic [15:0] op, input logic [15:0] cl, input logic [16:0] rh,
		input logic [9:0] bl, input logic [15:0] lon, input logic [15:0] lr);
		logic [16:0] junk;
		junk = 17'($urandom);
		cfg_write(bhsl_pkg::CFG_WINDOW_OPEN, {junk[16], op});
		cfg_write(bhsl_pkg::CFG_WINDOW_CLOSE, {junk[15], cl});
		cfg_write(bhsl_pkg::CFG_RESET_HOLD, rh);
		cfg_write(bhsl_pkg::CFG_BLINK_HALF, {junk[6:0], bl});
		cfg_write(bhsl_pkg::CFG_LINK_ON, {junk[14], lon});
		cfg_write(bhsl_pkg::CFG_LINK_REST, {junk[13], lr});
		cfg_valid <= 1'b0;
	endtask

	// mostly press/hold/release sequences around the thresholds, some raw noise
	task automatic gen_presses(input int unsigned count);
		int unsigned n, span, dur, rel, len;
		n = 0;
		span = th_open;
		if (th_close > span)
			span = th_close;
		if (th_reset > span)
			span = th_reset;
		while (n < count) begin
			if (one_in(5)) begin
				len = $urandom_range(1, 8);
				repeat (len) add_tick(1'($urandom_range(0, 1)), one_in(3), one_in(3));
				n += len;
			end else begin
				dur = $urandom_range(1, span + 8);
				rel = $urandom_range(1, 12);
				repeat (dur) add_tick(1'b1, one_in(6), one_in(6));
				repeat (rel) add_tick(1'b0, one_in(6), one_in(6));
				n += dur + rel;
			end
		end
	endtask

	initial begin
		tick_t row;
		status_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		idle_on = 1'b1;
		for (int i = 0; i < 10; i++) begin
			row = ROWS_DEFAULT[i];
			tick_q.push_back(row);
		end
		quiesce();

		// short thresholds: hold through open, close and reset
		load_cfg(16'd20, 16'd40, 17'd60, 10'd3, 16'd5, 16'd10);
		@(negedge clk);
		idle_on = 1'b0;
		for (int i = 0; i < 70; i++)
			add_tick(1'b1, one_in(8), one_in(8));
		add_tick(1'b0, 1'b0, 1'b0);
		quiesce();

		load_cfg('0, '0, '0, '0, '0, '0);
		@(negedge clk);
		idle_on = 1'b1;
		for (int i = 0; i < 8; i++) begin
			row = ROWS_ZERO[i];
			tick_q.push_back(row);
		end
		quiesce();

		// largest thresholds: no window, pulse never ends
		load_cfg('1, '1, '1, '1, '1, '1);
		@(negedge clk);
		idle_on = 1'b0;
		for (int i = 0; i < 30; i++)
			add_tick(1'b1, one_in(4), one_in(4));
		add_tick(1'b0, 1'b0, 1'b0);
		add_tick(1'b0, 1'b0, 1'b1);
		for (int i = 0; i < 40; i++)
			add_tick(1'b0, one_in(3), one_in(3));
		quiesce();

		// on time zero ends the pulse at the next check, short rest gap
		cfg_write(bhsl_pkg::CFG_LINK_ON, '0);
		cfg_write(bhsl_pkg::CFG_LINK_REST, 17'd4);
		cfg_valid <= 1'b0;
		@(negedge clk);
		for (int i = 0; i < 60; i++)
			add_tick(1'b0, one_in(3), one_in(3));
		quiesce();

		for (int p = 0; p < N_RAND; p++) begin
			load_cfg(16'($urandom_range(0, 20)), 16'($urandom_range(0, 40)),
				17'($urandom_range(0, 60)), 10'($urandom_range(0, 6)),
				16'($urandom_range(0, 10)), 16'($urandom_range(0, 20)));
			if (p == 0) begin
				cfg_write(CFG_SPARE, bhsl_pkg::CFG_DATA_W'($urandom));
				cfg_valid <= 1'b0;
			end
			@(negedge clk);
			idle_on = (p < N_RAND - 1);
			gen_presses(RAND_ITEMS / 2);
			if (p == 1)
				long_hold_req = 1'b1;
			quiesce();
			@(negedge clk);
			gen_presses(RAND_ITEMS / 2);
			quiesce();
		end

		repeat (8) @(posedge clk);
		$display("%0d ticks checked: directed rows, holds through every threshold, link times",
			n_items);
		$display("%0d random threshold settings with press sequences and stalls on both sides",
			N_RAND);
		if (errors == 0)
			$display("button_hold_and_status_led_controller: match");
		else
			$display("button_hold_and_status_led_controller: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bhsl_pkg.sv
src/bhsl_cfg_regs.sv
src/bhsl_tick.sv
src/button_hold_and_status_led_controller.sv
tb/tb.sv
